FILE: src/sler_pkg.sv
// ----------------------------------------------------------------------------
// sler_pkg: shared types and constants for the serial line edit ring buffers
// Event codes, control characters and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package sler_pkg;

    // Event codes carried on the op port.
    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_APP_WR  = 2'd1,
        OP_APP_RD  = 2'd2,
        OP_TX_SLOT = 2'd3
    } op_t;

    // Control characters used by the line editor.
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_BEL = 8'h07;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: src/serial_line_edit_ring_buffers_core.sv
// ----------------------------------------------------------------------------
// serial_line_edit_ring_buffers_core: receive and transmit rings with echo
// An event is taken when start is high and busy is low; its result is strobed
// by done in the cycle after the transfer cycle.
// No new event is taken in the finishing cycle, as busy is high with done;
// the single transmit memory write port may take two echo bytes per event.
// Reset clears the ring pointers and the sequencer; memory contents are left
// as they are. The receiver of results cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_line_edit_ring_buffers_core
    import sler_pkg::*;
#(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] op,
    input  wire logic [7:0] data,
    output logic            done,
    output logic [7:0]      read_data,
    output logic            read_valid,
    output logic [7:0]      send_data,
    output logic            send_valid,
    output logic            line_ready,
    output logic            send_dropped,
    output logic            send_pending
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // Ring storage, one synchronous memory per ring.
    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];
    logic [7:0] rx_rd_reg;
    logic [7:0] tx_rd_reg;

    // Control state.
    state_t             state_reg, state_next;
    logic [RX_AW-1:0]   rx_head_reg, rx_head_next;
    logic [RX_AW-1:0]   rx_tail_reg, rx_tail_next;
    logic [TX_AW-1:0]   tx_head_reg, tx_head_next;
    logic [TX_AW-1:0]   tx_tail_reg, tx_tail_next;

    // Per-event flags carried into the finishing cycle.
    logic       push2_reg, push2_next;
    logic [7:0] push2_byte_reg, push2_byte_next;
    logic       drop1_reg, drop1_next;
    logic       line_reg, line_next;
    logic       rv_reg, rv_next;
    logic       sv_reg, sv_next;

    // Decode and memory write controls.
    logic             accept;
    logic [7:0]       c_eff;
    logic             is_erase;
    logic             rx_empty, rx_full, tx_empty, tx_full;
    logic [RX_AW-1:0] rx_head_inc, rx_head_dec, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
    logic             push1;
    logic [7:0]       push1_byte;
    logic             rx_we;
    logic             tx_we;
    logic [7:0]       tx_wdata;
    logic             drop2;

    // Pointer arithmetic with wrap at the configured depth.
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_head_dec = (rx_head_reg == '0) ? RX_LAST : rx_head_reg - 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;

    assign rx_empty = (rx_head_reg == rx_tail_reg);
    assign rx_full  = (rx_head_inc == rx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign tx_full  = (tx_head_inc == tx_tail_reg);

    assign accept   = start && !busy;
    assign c_eff    = (data == CH_CR) ? CH_LF : data;
    assign is_erase = (c_eff == CH_BS) || (c_eff == CH_DEL);

    // Sequencer: next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                busy       = 1'b1;
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Event decode in the transfer cycle, second echo byte in the finishing cycle.
    always_comb
    begin
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        push2_next      = push2_reg;
        push2_byte_next = push2_byte_reg;
        drop1_next      = drop1_reg;
        line_next       = line_reg;
        rv_next         = rv_reg;
        sv_next         = sv_reg;
        push1           = 1'b0;
        push1_byte      = data;
        rx_we           = 1'b0;
        tx_we           = 1'b0;
        tx_wdata        = push1_byte;
        drop2           = 1'b0;

        if (accept)
        begin
            push2_next      = 1'b0;
            push2_byte_next = data;
            line_next       = 1'b0;
            rv_next         = 1'b0;
            sv_next         = 1'b0;
            case (op)
                OP_RX_BYTE:
                begin
                    push1 = 1'b1;
                    if (is_erase)
                    begin
                        push1_byte = rx_empty ? CH_BEL : c_eff;
                        if (!rx_empty)
                        begin
                            rx_head_next = rx_head_dec;
                        end
                    end
                    else if (rx_full)
                    begin
                        push1_byte = CH_BEL;
                    end
                    else
                    begin
                        push1_byte      = c_eff;
                        rx_we           = 1'b1;
                        rx_head_next    = rx_head_inc;
                        push2_next      = (c_eff == CH_LF);
                        push2_byte_next = CH_CR;
                        line_next       = (c_eff == CH_LF);
                    end
                end
                OP_APP_WR:
                begin
                    // Carriage return goes out ahead of a newline.
                    push1           = 1'b1;
                    push1_byte      = (data == CH_LF) ? CH_CR : data;
                    push2_next      = (data == CH_LF);
                    push2_byte_next = data;
                end
                OP_APP_RD:
                begin
                    if (!rx_empty)
                    begin
                        rv_next      = 1'b1;
                        rx_tail_next = rx_tail_inc;
                    end
                end
                OP_TX_SLOT:
                begin
                    if (!tx_empty)
                    begin
                        sv_next      = 1'b1;
                        tx_tail_next = tx_tail_inc;
                    end
                end
                default:
                begin
                    push1 = 1'b0;
                end
            endcase

            // First transmit push.
            drop1_next = push1 && tx_full;
            if (push1 && !tx_full)
            begin
                tx_we        = 1'b1;
                tx_wdata     = push1_byte;
                tx_head_next = tx_head_inc;
            end
        end
        else if (state_reg == ST_FINISH && push2_reg)
        begin
            // Second transmit push, against the pointers left by the first.
            drop2 = tx_full;
            if (!tx_full)
            begin
                tx_we        = 1'b1;
                tx_wdata     = push2_byte_reg;
                tx_head_next = tx_head_inc;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            push2_reg   <= 1'b0;
            drop1_reg   <= 1'b0;
            line_reg    <= 1'b0;
            rv_reg      <= 1'b0;
            sv_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            push2_reg   <= push2_next;
            drop1_reg   <= drop1_next;
            line_reg    <= line_next;
            rv_reg      <= rv_next;
            sv_reg      <= sv_next;
        end
    end

    // Payload register for the second echo byte.
    always_ff @(posedge clk)
    begin
        push2_byte_reg <= push2_byte_next;
    end

    // Receive memory: write at head, read at tail every cycle.
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_head_reg] <= c_eff;
        end
        rx_rd_reg <= rx_mem[rx_tail_reg];
    end

    // Transmit memory: write at head, read at tail every cycle.
    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_head_reg] <= tx_wdata;
        end
        tx_rd_reg <= tx_mem[tx_tail_reg];
    end

    // Result fields, valid while done is high.
    assign read_data    = rv_reg ? rx_rd_reg : 8'h00;
    assign read_valid   = rv_reg;
    assign send_data    = sv_reg ? tx_rd_reg : 8'h00;
    assign send_valid   = sv_reg;
    assign line_ready   = line_reg;
    assign send_dropped = drop1_reg || drop2;
    assign send_pending = (tx_head_next != tx_tail_reg);

endmodule

`default_nettype wire
